[design/msbbp_pkg.sv]
// shared types and constants for the msb-first bit packer
package msbbp_pkg;

  // longest code accepted, clamped to the width of the code field
  localparam int MAX_CODE_LEN   = 32;
  localparam int CODE_FIELD_W   = 32;
  localparam int CODE_LIMIT     = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int BYTE_W         = 8;
  localparam int MAX_WORDS      = 4;
  localparam int WIN_W          = CODE_FIELD_W + BYTE_W;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [2:0]        wcnt_t;

  typedef enum logic [2:0] {
    OP_CODE   = 3'd0,
    OP_RAW8   = 3'd1,
    OP_RAW16  = 3'd2,
    OP_RAW32  = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  // trailer value when the last bit closed a full byte
  localparam byte_t TRAILER_FULL = 8'd8;

endpackage

[design/msb_first_bit_packer.sv]
// msb-first variable-length code bit packer, top level
//
// Input channel (in_valid / in_stall): one item per handshake, with in_op
// selecting code bits, raw 8/16/32-bit value or finish. Code bits are pushed
// bit 0 first into a byte accumulator; each completed byte is sent. Raw items
// send their bytes big-endian and leave pending code bits alone. Finish pads
// any partial byte with zeros and sends it, then sends a trailer word
// holding the valid-bit count of the last stream byte.
// Output channel (out_valid / out_stall): one word per handshake, out_last set
// on the final word caused by an input item.
// An accepted item is loaded into the pending words; its first word then
// moves to the output register, from where the receiver can take it.
// Words leave one per cycle through the single output register while the
// receiver does not stall; an item may cause no words at all. Up to four
// words per item, as for a 32-bit raw write. The next item is taken in the
// cycle the last pending word moves to the output register.
// Reset (rst_n low, synchronous) empties the pending words and output and
// clears the accumulator, bit count and byte-done flag.
// When the receiver stalls, the output word holds; the input side stalls
// while words are pending, unless the last one moves to the output register.
module msb_first_bit_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_code_bits,
  input  logic [5:0]           in_code_len,
  input  logic [31:0]          in_raw_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msbbp_pkg::byte_t     out_byte,
  output logic                 out_last
);
  import msbbp_pkg::*;

  // packer state
  byte_t      accum_r, accum_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       done_r, done_nxt;

  // pending words of the current item
  byte_t      pend_r   [MAX_WORDS];
  byte_t      pend_nxt [MAX_WORDS];
  wcnt_t      pend_cnt_r, pend_cnt_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_take;
  logic       in_acc;

  // code path signals
  logic [5:0]          len_c;
  logic [31:0]         rev_code;
  logic [31:0]         code_mask;
  logic [WIN_W-1:0]    win_acc;
  logic [WIN_W-1:0]    win_code;
  logic [WIN_W-1:0]    win;
  logic [WIN_W-1:0]    win_sh;
  logic [5:0]          tot;
  logic [2:0]          rem;
  byte_t               code_acc;

  // batch built from the accepted item
  byte_t      bat   [MAX_WORDS];
  wcnt_t      bat_cnt;

  assign out_take = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = !((pend_cnt_r == 3'd0) || ((pend_cnt_r == 3'd1) && out_take));

  // align accumulator bits and the reversed code into one window
  always_comb begin
    len_c = (in_code_len > 6'(CODE_LIMIT)) ? 6'(CODE_LIMIT) : in_code_len;
    for (int i = 0; i < CODE_FIELD_W; i++) begin
      rev_code[CODE_FIELD_W-1-i] = in_code_bits[i];
    end
    code_mask = ~(32'hFFFF_FFFF >> len_c);
    win_acc   = {accum_r, 32'b0} << (4'd8 - {1'b0, bit_cnt_r});
    win_code  = {rev_code & code_mask, 8'b0} >> bit_cnt_r;
    win       = win_acc | win_code;
    tot       = {3'b0, bit_cnt_r} + len_c;
    rem       = tot[2:0];
    win_sh    = win << {tot[5:3], 3'b0};
    code_acc  = win_sh[WIN_W-1 -: BYTE_W] >> (4'd8 - {1'b0, rem});
  end

  // per-item word list and next packer state
  always_comb begin
    accum_nxt   = accum_r;
    bit_cnt_nxt = bit_cnt_r;
    done_nxt    = done_r;
    bat_cnt     = 3'd0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      bat[i] = '0;
    end
    case (op_t'(in_op))
      OP_CODE: begin
        bat[0]  = win[39:32];
        bat[1]  = win[31:24];
        bat[2]  = win[23:16];
        bat[3]  = win[15:8];
        bat_cnt = tot[5:3];
        if (len_c != 6'd0) begin
          accum_nxt   = code_acc;
          bit_cnt_nxt = rem;
          done_nxt    = (rem == 3'd0);
        end
      end
      OP_RAW8: begin
        bat[0]  = in_raw_value[7:0];
        bat_cnt = 3'd1;
      end
      OP_RAW16: begin
        bat[0]  = in_raw_value[15:8];
        bat[1]  = in_raw_value[7:0];
        bat_cnt = 3'd2;
      end
      OP_RAW32: begin
        bat[0]  = in_raw_value[31:24];
        bat[1]  = in_raw_value[23:16];
        bat[2]  = in_raw_value[15:8];
        bat[3]  = in_raw_value[7:0];
        bat_cnt = 3'd4;
      end
      OP_FINISH: begin
        if (bit_cnt_r != 3'd0) begin
          // padded partial byte then its bit count
          bat[0]      = accum_r << (4'd8 - {1'b0, bit_cnt_r});
          bat[1]      = {5'b0, bit_cnt_r};
          bat_cnt     = 3'd2;
          accum_nxt   = '0;
          bit_cnt_nxt = 3'd0;
          done_nxt    = 1'b1;
        end else begin
          bat[0]  = done_r ? TRAILER_FULL : 8'd0;
          bat_cnt = 3'd1;
        end
      end
      default: begin
        bat_cnt = 3'd0;
      end
    endcase
  end

  // pending words and output register
  always_comb begin
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < MAX_WORDS; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    if (out_take) begin
      out_valid_nxt = (pend_cnt_r != 3'd0);
      out_byte_nxt  = pend_r[0];
      out_last_nxt  = (pend_cnt_r == 3'd1);
      if (pend_cnt_r != 3'd0) begin
        for (int i = 0; i < MAX_WORDS - 1; i++) begin
          pend_nxt[i] = pend_r[i+1];
        end
        pend_cnt_nxt = pend_cnt_r - 3'd1;
      end
    end
    if (in_acc) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        pend_nxt[i] = bat[i];
      end
      pend_cnt_nxt = bat_cnt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      bit_cnt_r   <= '0;
      done_r      <= 1'b0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        accum_r   <= accum_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        done_r    <= done_nxt;
      end
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
